[hdl/ows_pkg.sv]
// package for the one-wire rom search engine: request mode codes and search constants
// no dependencies; used by hdl/one_wire_rom_search.sv and bench/tb.sv
package ows_pkg;

  localparam int unsigned ROM_BITS     = 64;
  localparam int unsigned END_POSITION = 65;
  localparam int unsigned FAMILY_LIMIT = 9;

  localparam int unsigned POS_W = 7;
  localparam int unsigned FD_W  = 4;
  localparam int unsigned IDX_W = $clog2(ROM_BITS);

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_START  = 3'd1,
    MODE_PAIR   = 3'd2,
    MODE_TARGET = 3'd3,
    MODE_SKIP   = 3'd4
  } mode_t;

endpackage

[hdl/one_wire_rom_search.sv]
// one-wire rom search decision engine: one request in, one result out
// the result is registered at the edge that accepts its request
// throughput: one request per cycle while the result is not stalled; in_stall follows a stalled result register
// the search state is updated in the same edge that loads the result register
// reset (rst, synchronous): rom, discrepancies and last-device flag cleared, no pass open
// depends on hdl/ows_pkg.sv
module one_wire_rom_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic        presence_missing,
  input  logic        id_bit,
  input  logic        complement_bit,
  input  logic [7:0]  target_family,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        direction_valid,
  output logic        write_direction,
  output logic        pass_finished,
  output logic        pass_success,
  output logic [63:0] rom_code,
  output logic        last_device
);

  localparam logic [ows_pkg::POS_W-1:0] POS_ONE = ows_pkg::POS_W'(1);
  localparam logic [ows_pkg::POS_W-1:0] POS_END = ows_pkg::POS_W'(ows_pkg::END_POSITION);
  localparam logic [ows_pkg::POS_W-1:0] POS_FAM = ows_pkg::POS_W'(ows_pkg::FAMILY_LIMIT);
  localparam logic [ows_pkg::POS_W-1:0] POS_ROM = ows_pkg::POS_W'(ows_pkg::ROM_BITS);

  // search state
  logic [ows_pkg::ROM_BITS-1:0] rom;
  logic [ows_pkg::POS_W-1:0]    last_discrepancy;
  logic [ows_pkg::FD_W-1:0]     family_discrepancy;
  logic                         no_more_devices;
  logic [ows_pkg::POS_W-1:0]    bit_position;
  logic [ows_pkg::POS_W-1:0]    newest_zero_position;
  logic                         pass_active;

  logic [ows_pkg::ROM_BITS-1:0] rom_next;
  logic [ows_pkg::POS_W-1:0]    last_discrepancy_next;
  logic [ows_pkg::FD_W-1:0]     family_discrepancy_next;
  logic                         no_more_devices_next;
  logic [ows_pkg::POS_W-1:0]    bit_position_next;
  logic [ows_pkg::POS_W-1:0]    newest_zero_position_next;
  logic                         pass_active_next;

  logic dir_valid_next, dir_next, finished_next, success_next;

  logic                         accept;
  logic [ows_pkg::IDX_W-1:0]    idx;
  logic [ows_pkg::POS_W-1:0]    pos_inc;
  logic                         rom_bit;
  logic                         dir_pair;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign idx      = ows_pkg::IDX_W'(bit_position - POS_ONE);
  assign pos_inc  = bit_position + POS_ONE;
  assign rom_bit  = rom[idx];

  // direction where both id bits agree (a discrepancy)
  always_comb begin
    if (bit_position < last_discrepancy) begin
      dir_pair = rom_bit;
    end else begin
      dir_pair = (bit_position == last_discrepancy);
    end
  end

  always_comb begin
    rom_next                  = rom;
    last_discrepancy_next     = last_discrepancy;
    family_discrepancy_next   = family_discrepancy;
    no_more_devices_next      = no_more_devices;
    bit_position_next         = bit_position;
    newest_zero_position_next = newest_zero_position;
    pass_active_next          = pass_active;
    dir_valid_next            = 1'b0;
    dir_next                  = 1'b0;
    finished_next             = 1'b0;
    success_next              = 1'b0;

    case (ows_pkg::mode_t'(mode))
      ows_pkg::MODE_CLEAR: begin
        last_discrepancy_next     = '0;
        family_discrepancy_next   = '0;
        no_more_devices_next      = 1'b0;
        pass_active_next          = 1'b0;
        bit_position_next         = POS_ONE;
        newest_zero_position_next = '0;
      end
      ows_pkg::MODE_START: begin
        bit_position_next         = POS_ONE;
        newest_zero_position_next = '0;
        if (no_more_devices || presence_missing) begin
          last_discrepancy_next   = '0;
          family_discrepancy_next = '0;
          no_more_devices_next    = 1'b0;
          pass_active_next        = 1'b0;
          finished_next           = 1'b1;
        end else begin
          pass_active_next = 1'b1;
        end
      end
      ows_pkg::MODE_PAIR: begin
        if (pass_active) begin
          if (id_bit && complement_bit) begin
            // no device answered
            last_discrepancy_next     = '0;
            family_discrepancy_next   = '0;
            no_more_devices_next      = 1'b0;
            pass_active_next          = 1'b0;
            bit_position_next         = POS_ONE;
            newest_zero_position_next = '0;
            finished_next             = 1'b1;
          end else begin
            if (id_bit != complement_bit) begin
              dir_next = id_bit;
            end else begin
              dir_next = dir_pair;
              if (!dir_pair) begin
                newest_zero_position_next = bit_position;
                if (bit_position < POS_FAM) begin
                  family_discrepancy_next = ows_pkg::FD_W'(bit_position);
                end
              end
            end
            rom_next[idx]     = dir_next;
            dir_valid_next    = 1'b1;
            bit_position_next = pos_inc;
            if (pos_inc >= POS_END) begin
              finished_next           = 1'b1;
              last_discrepancy_next   = newest_zero_position_next;
              if (newest_zero_position_next == '0) begin
                no_more_devices_next = 1'b1;
              end
              pass_active_next          = 1'b0;
              bit_position_next         = POS_ONE;
              newest_zero_position_next = '0;
              if (rom_next[7:0] == 8'h00) begin
                // zero family byte counts as a failed pass
                last_discrepancy_next   = '0;
                family_discrepancy_next = '0;
                no_more_devices_next    = 1'b0;
              end else begin
                success_next = 1'b1;
              end
            end
          end
        end
      end
      ows_pkg::MODE_TARGET: begin
        pass_active_next          = 1'b0;
        bit_position_next         = POS_ONE;
        newest_zero_position_next = '0;
        rom_next                  = {{(ows_pkg::ROM_BITS-8){1'b0}}, target_family};
        last_discrepancy_next     = POS_ROM;
        no_more_devices_next      = 1'b0;
        family_discrepancy_next   = '0;
      end
      ows_pkg::MODE_SKIP: begin
        pass_active_next          = 1'b0;
        bit_position_next         = POS_ONE;
        newest_zero_position_next = '0;
        last_discrepancy_next     = ows_pkg::POS_W'(family_discrepancy);
        family_discrepancy_next   = '0;
        if (family_discrepancy == '0) begin
          no_more_devices_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom                  <= '0;
      last_discrepancy     <= '0;
      family_discrepancy   <= '0;
      no_more_devices      <= 1'b0;
      bit_position         <= POS_ONE;
      newest_zero_position <= '0;
      pass_active          <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      if (accept) begin
        rom                  <= rom_next;
        last_discrepancy     <= last_discrepancy_next;
        family_discrepancy   <= family_discrepancy_next;
        no_more_devices      <= no_more_devices_next;
        bit_position         <= bit_position_next;
        newest_zero_position <= newest_zero_position_next;
        pass_active          <= pass_active_next;
        out_valid            <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result flags; rom and last-device flag move only with a new result
  always_ff @(posedge clk) begin
    if (accept) begin
      direction_valid <= dir_valid_next;
      write_direction <= dir_next;
      pass_finished   <= finished_next;
      pass_success    <= success_next;
    end
  end

  assign rom_code    = rom;
  assign last_device = no_more_devices;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pass_active |-> (bit_position >= POS_ONE && bit_position <= POS_ROM))
    else $error("bit position out of range during a pass");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !pass_active |-> (bit_position == POS_ONE && newest_zero_position == '0))
    else $error("pass bookkeeping not cleared outside a pass");

  a_ld_range: assert property (@(posedge clk) disable iff (rst)
    last_discrepancy <= POS_ROM)
    else $error("last discrepancy beyond rom length");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(rom) && $stable(bit_position))
    else $error("search state moved while result stalled");

  a_no_answer: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == ows_pkg::MODE_PAIR && pass_active && id_bit && complement_bit)
    |=> (out_valid && pass_finished && !pass_success && !direction_valid && !pass_active))
    else $error("one-one pair did not fail the pass");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// testbench for one_wire_rom_search: directed special cases, simulated device buses and noise
// depends on hdl/ows_pkg.sv and hdl/one_wire_rom_search.sv
module tb;

  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int MAX_DEVICES = 8;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic        dir_valid;
    logic        dir;
    logic        finished;
    logic        success;
    logic [63:0] rom;
    logic        last_dev;
  } search_answer_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  mode = ows_pkg::MODE_CLEAR;
  logic        presence_missing = 1'b0;
  logic        id_bit = 1'b0;
  logic        complement_bit = 1'b0;
  logic [7:0]  target_family = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        direction_valid;
  logic        write_direction;
  logic        pass_finished;
  logic        pass_success;
  logic [63:0] rom_code;
  logic        last_device;

  one_wire_rom_search dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .presence_missing(presence_missing), .id_bit(id_bit),
    .complement_bit(complement_bit), .target_family(target_family),
    .out_valid(out_valid), .out_stall(out_stall),
    .direction_valid(direction_valid), .write_direction(write_direction),
    .pass_finished(pass_finished), .pass_success(pass_success),
    .rom_code(rom_code), .last_device(last_device)
  );

  // search state as the block should hold it
  logic [63:0] rom_image = '0;
  logic [6:0]  last_disc = '0;
  logic [3:0]  family_disc = '0;
  logic        devices_done = 1'b0;
  logic [6:0]  next_pos = 7'd1;
  logic [6:0]  newest_zero = '0;
  logic        pass_open = 1'b0;

  search_answer_t awaited_answers[$];
  search_answer_t latest_answer;
  logic [63:0]    bus_roms[$];

  int  requests_sent = 0;
  int  answers_checked = 0;
  int  passes_ended = 0;
  int  devices_found = 0;
  int  errors = 0;
  int  quiet_cycles = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_stalls = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void close_pass();
    pass_open = 1'b0;
    next_pos = 7'd1;
    newest_zero = '0;
  endfunction

  function automatic void restart_search();
    last_disc = '0;
    family_disc = '0;
    devices_done = 1'b0;
    close_pass();
  endfunction

  function automatic search_answer_t search_step(input logic [2:0] m, input logic pm,
                                                 input logic idb, input logic cmpb,
                                                 input logic [7:0] fam);
    search_answer_t r;
    logic [6:0] pos;
    logic [5:0] idx;
    logic d;
    r = '0;
    case (m)
      ows_pkg::MODE_CLEAR: restart_search();
      ows_pkg::MODE_START: begin
        close_pass();
        if (devices_done || pm) begin
          restart_search();
          r.finished = 1'b1;
        end else begin
          pass_open = 1'b1;
        end
      end
      ows_pkg::MODE_PAIR: begin
        if (pass_open && idb && cmpb) begin
          // nobody answered the slot
          restart_search();
          r.finished = 1'b1;
        end else if (pass_open) begin
          pos = next_pos;
          idx = 6'(pos - 7'd1);
          if (idb != cmpb) begin
            d = idb;
          end else begin
            if (pos < last_disc) d = rom_image[idx];
            else d = (pos == last_disc);
            if (!d) begin
              newest_zero = pos;
              if (pos < ows_pkg::FAMILY_LIMIT) family_disc = pos[3:0];
            end
          end
          rom_image[idx] = d;
          r.dir_valid = 1'b1;
          r.dir = d;
          next_pos = pos + 7'd1;
          if (next_pos >= ows_pkg::END_POSITION) begin
            r.finished = 1'b1;
            last_disc = newest_zero;
            if (last_disc == '0) devices_done = 1'b1;
            close_pass();
            if (rom_image[7:0] == 8'h00) restart_search();
            else r.success = 1'b1;
          end
        end
      end
      ows_pkg::MODE_TARGET: begin
        close_pass();
        rom_image = {56'b0, fam};
        last_disc = 7'(ows_pkg::ROM_BITS);
        devices_done = 1'b0;
        family_disc = '0;
      end
      ows_pkg::MODE_SKIP: begin
        close_pass();
        last_disc = {3'b000, family_disc};
        family_disc = '0;
        if (last_disc == '0) devices_done = 1'b1;
      end
      default: ;
    endcase
    r.rom = rom_image;
    r.last_dev = devices_done;
    return r;
  endfunction

  task automatic send_request(input logic [2:0] m, input logic pm, input logic idb,
                              input logic cmpb, input logic [7:0] fam);
    while (sender_idles && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    presence_missing <= pm;
    id_bit <= idb;
    complement_bit <= cmpb;
    target_family <= fam;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    latest_answer = search_step(m, pm, idb, cmpb, fam);
    awaited_answers.push_back(latest_answer);
    requests_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_answers.size() != 0) @(posedge clk);
  endtask

  task automatic fill_bus(input int n_dev);
    logic [63:0] rom;
    bus_roms.delete();
    repeat (n_dev) begin
      rom = {$urandom, $urandom};
      // crowd the family byte so that family discrepancies turn up
      if ($urandom_range(3) != 0) rom[7:0] = 8'h20 | 8'($urandom_range(3));
      bus_roms.push_back(rom);
    end
  endtask

  // one search pass against the simulated bus, following the predicted direction
  task automatic run_bus_pass();
    bit   alive [MAX_DEVICES];
    logic idb;
    logic cmpb;
    for (int i = 0; i < MAX_DEVICES; i++) alive[i] = (i < bus_roms.size());
    send_request(ows_pkg::MODE_START, bus_roms.size() == 0, 1'($urandom), 1'($urandom),
                 8'($urandom));
    if (latest_answer.finished) return;
    for (int b = 0; b < ows_pkg::ROM_BITS; b++) begin
      idb = 1'b1;
      cmpb = 1'b1;
      foreach (bus_roms[i]) begin
        if (alive[i]) begin
          idb &= bus_roms[i][b];
          cmpb &= ~bus_roms[i][b];
        end
      end
      send_request(ows_pkg::MODE_PAIR, 1'($urandom), idb, cmpb, 8'($urandom));
      if (!latest_answer.dir_valid) return;
      foreach (bus_roms[i]) if (bus_roms[i][b] != latest_answer.dir) alive[i] = 1'b0;
    end
  endtask

  task automatic test_special_cases();
    send_request(ows_pkg::MODE_PAIR, 1'b0, 1'b0, 1'b1, 8'h00);
    send_request(ows_pkg::MODE_START, 1'b1, 1'b0, 1'b0, 8'h00);
    send_request(ows_pkg::MODE_START, 1'b0, 1'b0, 1'b0, 8'h00);
    send_request(ows_pkg::MODE_PAIR, 1'b0, 1'b1, 1'b1, 8'hFF);
    send_request(ows_pkg::MODE_START, 1'b0, 1'b1, 1'b1, 8'hFF);
    send_request(ows_pkg::MODE_PAIR, 1'b1, 1'b0, 1'b0, 8'h00);
    send_request(ows_pkg::MODE_PAIR, 1'b0, 1'b1, 1'b0, 8'h00);
    send_request(ows_pkg::MODE_PAIR, 1'b0, 1'b0, 1'b1, 8'h00);
    send_request(ows_pkg::MODE_START, 1'b0, 1'b0, 1'b0, 8'h00);
    send_request(ows_pkg::MODE_PAIR, 1'b0, 1'b0, 1'b0, 8'h00);
    send_request(ows_pkg::MODE_CLEAR, 1'b1, 1'b1, 1'b1, 8'hFF);
    send_request(ows_pkg::MODE_START, 1'b0, 1'b0, 1'b0, 8'h00);
    send_request(ows_pkg::MODE_PAIR, 1'b0, 1'b1, 1'b0, 8'h00);
    send_request(ows_pkg::MODE_TARGET, 1'b0, 1'b0, 1'b0, 8'hFF);
    send_request(ows_pkg::MODE_SKIP, 1'b0, 1'b0, 1'b0, 8'h00);
    send_request(ows_pkg::MODE_START, 1'b0, 1'b0, 1'b0, 8'h00);
    send_request(ows_pkg::MODE_TARGET, 1'b1, 1'b1, 1'b1, 8'h00);
    send_request(ows_pkg::MODE_TARGET, 1'b0, 1'b0, 1'b0, 8'hA5);
    send_request(ows_pkg::MODE_START, 1'b0, 1'b0, 1'b0, 8'h00);
    send_request(ows_pkg::MODE_PAIR, 1'b0, 1'b0, 1'b0, 8'h00);
    send_request(ows_pkg::MODE_SKIP, 1'b1, 1'b1, 1'b1, 8'hFF);
    for (logic [3:0] m = 4'(MODE_SPARE_LO); m <= 4'(MODE_SPARE_HI); m++)
      send_request(m[2:0], 1'b1, 1'b1, 1'b1, 8'hFF);
    send_request(ows_pkg::MODE_CLEAR, 1'b0, 1'b0, 1'b0, 8'h00);
  endtask

  task automatic test_zero_family();
    bus_roms.delete();
    bus_roms.push_back({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00);
    run_bus_pass();
    run_bus_pass();
  endtask

  task automatic test_enumeration();
    int rounds;
    rounds = 0;
    while (requests_sent < 850) begin
      // the first buses run without any idling on either side
      sender_idles = (rounds >= 2);
      receiver_stalls = (rounds >= 2);
      fill_bus($urandom_range(6, 1));
      send_request(ows_pkg::MODE_CLEAR, 1'($urandom), 1'($urandom), 1'($urandom),
                   8'($urandom));
      repeat (bus_roms.size() + 2) begin
        run_bus_pass();
        if (latest_answer.last_dev || !latest_answer.success) break;
      end
      rounds++;
    end
  endtask

  task automatic test_family_target_and_skip();
    while (requests_sent < 1050) begin
      fill_bus($urandom_range(5, 2));
      send_request(ows_pkg::MODE_TARGET, 1'($urandom), 1'($urandom), 1'($urandom),
                   bus_roms[$urandom_range(bus_roms.size() - 1)][7:0]);
      run_bus_pass();
      if ($urandom_range(1)) begin
        send_request(ows_pkg::MODE_SKIP, 1'($urandom), 1'($urandom), 1'($urandom),
                     8'($urandom));
        run_bus_pass();
      end
      run_bus_pass();
    end
  endtask

  task automatic test_random_noise();
    int pick;
    logic [2:0] m;
    logic idb;
    while (requests_sent < 1250) begin
      pick = $urandom_range(99);
      if (pick < 8) m = ows_pkg::MODE_CLEAR;
      else if (pick < 22) m = ows_pkg::MODE_START;
      else if (pick < 82) m = ows_pkg::MODE_PAIR;
      else if (pick < 89) m = ows_pkg::MODE_TARGET;
      else if (pick < 95) m = ows_pkg::MODE_SKIP;
      else m = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
      idb = 1'($urandom);
      send_request(m, $urandom_range(4) == 0, idb,
                   ($urandom_range(3) == 0) ? idb : ~idb, 8'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_zero_family();
    wait_for_results();
    test_enumeration();
    wait_for_results();
    test_family_target_and_skip();
    test_random_noise();
    wait_for_results();
    repeat (4) @(posedge clk);
    $display("%0d requests sent, %0d results checked", requests_sent, answers_checked);
    $display("%0d search passes ended, %0d of them found a device", passes_ended,
             devices_found);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= receiver_stalls && ($urandom_range(99) < 37);
  end

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    search_answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got rom %h", $time, rom_code);
        errors++;
      end else begin
        want = awaited_answers.pop_front();
        compare_field("direction_valid", 64'(want.dir_valid), 64'(direction_valid));
        compare_field("write_direction", 64'(want.dir), 64'(write_direction));
        compare_field("pass_finished", 64'(want.finished), 64'(pass_finished));
        compare_field("pass_success", 64'(want.success), 64'(pass_success));
        compare_field("rom_code", want.rom, rom_code);
        compare_field("last_device", 64'(want.last_dev), 64'(last_device));
        answers_checked++;
        if (want.finished) passes_ended++;
        if (want.success) devices_found++;
      end
    end
  end

  // nothing accepted on either side for too long means the block has hung
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

[files.f]
hdl/ows_pkg.sv
hdl/one_wire_rom_search.sv
bench/tb.sv
